// ----- hw/rtl/cps_pkg.sv -----
package cps_pkg;

  // Default depth of the pair list.
  localparam int unsigned LIST_DEPTH_DEF = 64;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned PART_W  = 12;
  localparam int unsigned IMAGE_W = 5;

  // Key held by empty entries straight after reset.
  localparam logic [KEY_W-1:0] EMPTY_RESET = 32'hFFFF_FFFF;

  // Operation codes carried on s_tuser.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Register index of empty_distance on the configuration port.
  localparam logic REG_EMPTY_DISTANCE = 1'b0;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PART_W-1:0]  first;
    logic [PART_W-1:0]  second;
    logic [IMAGE_W-1:0] image;
    logic               valid;
  } entry_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [KEY_W-1:0]   key;
    logic [PART_W-1:0]  first;
    logic [PART_W-1:0]  second;
    logic [IMAGE_W-1:0] image;
  } item_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_INS_RD,
    S_INS_EX,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_EX,
    S_FILL,
    S_HEAD_RD,
    S_HEAD_EX
  } state_t;

endpackage

// ----- hw/rtl/cps_engine.sv -----
module cps_engine #(
  parameter int unsigned LIST_DEPTH = cps_pkg::LIST_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  cps_pkg::item_t              item,
  input  logic [cps_pkg::KEY_W-1:0]   empty_distance,
  input  logic                        out_free,
  output logic                        idle,
  output logic                        done,
  output cps_pkg::entry_t             head
);

  localparam int unsigned IDX_W = $clog2(LIST_DEPTH);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(LIST_DEPTH - 1);

  cps_pkg::entry_t mem [LIST_DEPTH];
  cps_pkg::entry_t rdata;

  cps_pkg::state_t state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] wr_idx, wr_idx_next;
  cps_pkg::item_t   cur;

  logic             we;
  logic [IDX_W-1:0] waddr;
  cps_pkg::entry_t  wdata;
  logic [IDX_W-1:0] raddr;

  cps_pkg::entry_t  new_entry;
  cps_pkg::entry_t  empty_entry;
  cps_pkg::entry_t  reset_entry;
  logic             match;

  assign new_entry   = '{key: cur.key, first: cur.first, second: cur.second,
                         image: cur.image, valid: 1'b1};
  assign empty_entry = '{key: empty_distance, first: '0, second: '0,
                         image: '0, valid: 1'b0};
  assign reset_entry = '{key: cps_pkg::EMPTY_RESET, first: '0, second: '0,
                         image: '0, valid: 1'b0};

  // Only real entries can be removed by a delete.
  assign match = rdata.valid && (rdata.first == cur.first || rdata.second == cur.first);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= cps_pkg::S_INIT;
      idx    <= '0;
      wr_idx <= '0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      wr_idx <= wr_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && idle) begin
      cur <= item;
    end
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    wr_idx_next = wr_idx;
    we          = 1'b0;
    waddr       = idx;
    wdata       = empty_entry;
    raddr       = idx;
    done        = 1'b0;
    unique case (state)
      cps_pkg::S_INIT: begin
        we    = 1'b1;
        wdata = reset_entry;
        if (idx == LAST) begin
          state_next = cps_pkg::S_IDLE;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      cps_pkg::S_IDLE: begin
        if (start) begin
          unique case (item.op)
            cps_pkg::OP_INSERT: begin
              idx_next   = LAST;
              state_next = cps_pkg::S_INS_RD;
            end
            cps_pkg::OP_DELETE: begin
              idx_next    = '0;
              wr_idx_next = '0;
              state_next  = cps_pkg::S_DEL_RD;
            end
            cps_pkg::OP_CLEAR: begin
              idx_next   = '0;
              state_next = cps_pkg::S_FILL;
            end
            default: begin
              state_next = cps_pkg::S_HEAD_RD;
            end
          endcase
        end
      end
      cps_pkg::S_INS_RD: begin
        state_next = cps_pkg::S_INS_EX;
      end
      cps_pkg::S_INS_EX: begin
        if (cur.key < rdata.key) begin
          // This entry moves down one place; the last one falls off.
          if (idx != LAST) begin
            we    = 1'b1;
            waddr = idx + IDX_W'(1);
            wdata = rdata;
          end
          if (idx == '0) begin
            state_next = cps_pkg::S_INS_PUT;
          end else begin
            idx_next   = idx - IDX_W'(1);
            state_next = cps_pkg::S_INS_RD;
          end
        end else begin
          if (idx != LAST) begin
            we    = 1'b1;
            waddr = idx + IDX_W'(1);
            wdata = new_entry;
          end
          state_next = cps_pkg::S_HEAD_RD;
        end
      end
      cps_pkg::S_INS_PUT: begin
        we         = 1'b1;
        waddr      = '0;
        wdata      = new_entry;
        state_next = cps_pkg::S_HEAD_RD;
      end
      cps_pkg::S_DEL_RD: begin
        state_next = cps_pkg::S_DEL_EX;
      end
      cps_pkg::S_DEL_EX: begin
        if (!match) begin
          if (wr_idx != idx) begin
            we    = 1'b1;
            waddr = wr_idx;
            wdata = rdata;
          end
          wr_idx_next = wr_idx + IDX_W'(1);
        end
        if (idx == LAST) begin
          if (!match && wr_idx == idx) begin
            state_next = cps_pkg::S_HEAD_RD;
          end else begin
            idx_next   = wr_idx_next;
            state_next = cps_pkg::S_FILL;
          end
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = cps_pkg::S_DEL_RD;
        end
      end
      cps_pkg::S_FILL: begin
        we    = 1'b1;
        wdata = empty_entry;
        if (idx == LAST) begin
          state_next = cps_pkg::S_HEAD_RD;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      cps_pkg::S_HEAD_RD: begin
        raddr      = '0;
        state_next = cps_pkg::S_HEAD_EX;
      end
      cps_pkg::S_HEAD_EX: begin
        raddr = '0;
        if (out_free) begin
          done       = 1'b1;
          state_next = cps_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cps_pkg::S_IDLE;
      end
    endcase
  end

  assign idle = (state == cps_pkg::S_IDLE);
  assign head = rdata;

endmodule

// ----- hw/rtl/closest_pair_sorted_list.sv -----
// Every op ends by reading the head entry: clear rewrites every entry, insert walks up
// from the tail, delete compacts the list; an unused op code only reads the head. One word is taken at a time.
// List entries are visited one at a time through the list memory's single read port.
// Reset (synchronous, active high) empties the output register, sets empty_distance
// to all ones and starts a pass that writes every entry empty;
// s_tready stays low during that pass.
module closest_pair_sorted_list #(
  parameter int unsigned LIST_DEPTH = cps_pkg::LIST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input word stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // pair_key, first_particle, second_particle, image_box
  input  logic [1:0]  s_tuser,   // op
  // Result word stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // head_key, head_first, head_second, head_image
  output logic [0:0]  m_tuser,   // head_valid
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [cps_pkg::KEY_W-1:0] empty_distance;
  cps_pkg::item_t            item;
  cps_pkg::entry_t           head;
  cps_pkg::entry_t           out_word;
  logic                      idle;
  logic                      done;
  logic                      out_free;

  // The register lies at byte address 0; paddr[2] selects a register word.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == cps_pkg::REG_EMPTY_DISTANCE) ? empty_distance : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_distance <= cps_pkg::EMPTY_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == cps_pkg::REG_EMPTY_DISTANCE) begin
      empty_distance <= pwdata;
    end
  end

  // Unpack the incoming word.
  assign item.op     = s_tuser;
  assign item.key    = s_tdata[31:0];
  assign item.first  = s_tdata[43:32];
  assign item.second = s_tdata[55:44];
  assign item.image  = s_tdata[60:56];

  // A new word is taken only while the sequencer sits idle; the output
  // register may still hold the previous result at that time.
  assign s_tready = idle;

  // The sequencer hands over the head entry only when the output register
  // is empty or being emptied in the same cycle, so no result is lost.
  assign out_free = !m_tvalid || m_tready;

  cps_engine #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .start         (s_tvalid),
    .item          (item),
    .empty_distance(empty_distance),
    .out_free      (out_free),
    .idle          (idle),
    .done          (done),
    .head          (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_word <= head;
    end
  end

  assign m_tdata = {3'b000, out_word.image, out_word.second, out_word.first, out_word.key};
  assign m_tuser = out_word.valid;

endmodule
